// ===== rtl/core/rbqs_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring buffer queue/stack package
// Operation codes, field widths and register constants shared by the core.
// ----------------------------------------------------------------------------
package rbqs_pkg;

   // Widths of the fixed fields.
   localparam int OPCODE_W   = 3;
   localparam int WORD_W     = 32;
   localparam int COUNT_W    = 13;
   localparam int SIZE_W     = 14;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // Ring size after reset, before clamping to the storage depth.
   localparam int SIZE_RESET = 8192;

   // Operation codes.
   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_DEQ   = 3'd2,
      OP_CLEAR = 3'd3,
      OP_TAKE  = 3'd4
   } rbqs_op_type;

endpackage

// ===== rtl/core/rbqs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle: a write, or a read whose data is registered.
// ----------------------------------------------------------------------------
module rbqs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write or registered read at the selected address.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/ring_buffer_queue_stack_core.sv =====
// ----------------------------------------------------------------------------
// Ring buffer queue/stack core
// Ring of 64-bit point slots used as a stack (push/pop at the front) or as a
// queue (push at the front, dequeue at the back), with live and peak counts.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred at a rising edge with start high; busy is always
//   low, so a new command may be issued in every cycle. Each command yields
//   exactly one result, shown for one cycle with rsp_strobe high, in the cycle
//   after the command transfer. The receiver cannot stall the result.
//   Throughput is one command per cycle; results are registered, and the
//   slot RAM, with its registered read, is accessed at most once per command.
//   The APB port holds active_size; paddr is not decoded. Writing it clears
//   the ring (pointers and counts); write it only while no command is in flight.
//   Reset clears pointers, counts and the captured point and sets the ring
//   size to its reset value. Slot contents are not cleared; only slots that
//   were pushed are ever read back.
// ----------------------------------------------------------------------------
module ring_buffer_queue_stack_core #(
   parameter int DEPTH = 8192
) (
   input  logic                              clock,
   input  logic                              reset,
   // Command channel
   input  logic                              start,
   output logic                              busy,
   input  logic [rbqs_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [rbqs_pkg::WORD_W-1:0]       req_in_x,
   input  logic [rbqs_pkg::WORD_W-1:0]       req_in_y,
   // Result channel
   output logic                              rsp_strobe,
   output logic                              rsp_ok,
   output logic [rbqs_pkg::WORD_W-1:0]       rsp_out_x,
   output logic [rbqs_pkg::WORD_W-1:0]       rsp_out_y,
   output logic                              rsp_is_empty,
   output logic                              rsp_almost_full,
   output logic [rbqs_pkg::COUNT_W-1:0]      rsp_live_count,
   output logic [rbqs_pkg::COUNT_W-1:0]      rsp_peak_count,
   // Configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rbqs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rbqs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rbqs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   import rbqs_pkg::*;

   localparam int IW    = $clog2(DEPTH);
   localparam int IWP   = IW + 1;
   localparam int CMPW  = (IWP > SIZE_W) ? IWP : SIZE_W;
   localparam int SLOTW = 2 * WORD_W;
   localparam int SIZE_RESET_M1 = ((SIZE_RESET > DEPTH) ? DEPTH : SIZE_RESET) - 1;

   // Configuration state.
   logic [SIZE_W-1:0] active_size_ff;
   logic [IW-1:0]     size_m1_ff;
   logic [IW-1:0]     size_m1_in;
   logic [CMPW-1:0]   wsize;
   logic              cfg_we;

   // Ring state.
   logic [IW-1:0]     front_ff, front_in;
   logic [IW-1:0]     back_ff, back_in;
   logic [IW-1:0]     held_ff, held_in;
   logic [IW-1:0]     high_ff, high_in;
   logic [WORD_W-1:0] cap_x_ff, cap_x_in;
   logic [WORD_W-1:0] cap_y_ff, cap_y_in;

   // Result stage.
   logic              strobe_ff;
   logic              ok_ff, ok_in;
   logic              sel_mem_ff, sel_mem_in;
   logic [WORD_W-1:0] take_x_ff, take_x_in;
   logic [WORD_W-1:0] take_y_ff, take_y_in;
   logic              empty_ff, empty_in;
   logic              afull_ff, afull_in;

   // Index arithmetic.
   logic              accept;
   logic              not_empty;
   logic [IW-1:0]     front_inc, front_dec, back_inc, held_plus, held_minus;
   logic [IWP-1:0]    front2;

   // Slot RAM access.
   logic              ram_en, ram_we;
   logic [IW-1:0]     ram_addr;
   logic [SLOTW-1:0]  ram_wdata, ram_rdata;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // APB register access; a single register, and paddr is not decoded.
   assign pready = 1'b1;
   assign cfg_we = psel & penable & pwrite & pready;
   assign prdata = CSR_DATA_W'(active_size_ff);

   // Clamp a written ring size to 2..DEPTH and keep it as size minus one.
   always_comb begin
      wsize = CMPW'(pwdata[SIZE_W-1:0]);
      if (wsize < CMPW'(2)) begin
         size_m1_in = IW'(1);
      end else if (wsize > CMPW'(DEPTH)) begin
         size_m1_in = IW'(DEPTH - 1);
      end else begin
         size_m1_in = IW'(wsize - CMPW'(1));
      end
   end

   // Neighbor indices with wrap at the ring size; held count plus or minus one, floored at zero.
   assign front_inc  = (front_ff == size_m1_ff) ? '0 : front_ff + IW'(1);
   assign front_dec  = (front_ff == '0) ? size_m1_ff : front_ff - IW'(1);
   assign back_inc   = (back_ff == size_m1_ff) ? '0 : back_ff + IW'(1);
   assign held_plus  = held_ff + IW'(1);
   assign held_minus = (held_ff != '0) ? held_ff - IW'(1) : held_ff;
   assign not_empty  = (front_ff != back_ff);
   assign ram_wdata  = {req_in_y, req_in_x};

   // Operation decode and next state.
   always_comb begin
      front_in   = front_ff;
      back_in    = back_ff;
      held_in    = held_ff;
      high_in    = high_ff;
      cap_x_in   = cap_x_ff;
      cap_y_in   = cap_y_ff;
      ok_in      = 1'b0;
      sel_mem_in = 1'b0;
      take_x_in  = '0;
      take_y_in  = '0;
      ram_en     = 1'b0;
      ram_we     = 1'b0;
      ram_addr   = front_ff;
      unique case (rbqs_op_type'(req_opcode))
         OP_PUSH: begin
            if (front_inc != back_ff) begin
               ram_en   = accept;
               ram_we   = 1'b1;
               front_in = front_inc;
               held_in  = held_plus;
               ok_in    = 1'b1;
               if (held_plus > high_ff) begin
                  high_in  = held_plus;
                  cap_x_in = req_in_x;
                  cap_y_in = req_in_y;
               end
            end
         end
         OP_POP: begin
            if (not_empty) begin
               ram_en     = accept;
               ram_addr   = front_dec;
               front_in   = front_dec;
               held_in    = held_minus;
               ok_in      = 1'b1;
               sel_mem_in = 1'b1;
            end
         end
         OP_DEQ: begin
            if (not_empty) begin
               ram_en     = accept;
               ram_addr   = back_ff;
               back_in    = back_inc;
               held_in    = held_minus;
               ok_in      = 1'b1;
               sel_mem_in = 1'b1;
            end
         end
         OP_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            held_in  = '0;
            high_in  = '0;
         end
         OP_TAKE: begin
            take_x_in = cap_x_ff;
            take_y_in = cap_y_ff;
            ok_in     = (cap_x_ff != '0) || (cap_y_ff != '0);
            cap_x_in  = '0;
            cap_y_in  = '0;
            high_in   = held_ff;
         end
         default: begin
         end
      endcase
   end

   // Status after the operation; front plus two wraps at most once.
   always_comb begin
      front2 = {1'b0, front_in} + IWP'(2);
      if (front2 > {1'b0, size_m1_ff}) begin
         front2 = front2 - {1'b0, size_m1_ff} - IWP'(1);
      end
      empty_in = (front_in == back_in);
      afull_in = (front2 == {1'b0, back_in});
   end

   // Control and ring state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_size_ff <= SIZE_W'(SIZE_RESET);
         size_m1_ff     <= IW'(SIZE_RESET_M1);
         front_ff       <= '0;
         back_ff        <= '0;
         held_ff        <= '0;
         high_ff        <= '0;
         cap_x_ff       <= '0;
         cap_y_ff       <= '0;
         strobe_ff      <= 1'b0;
      end else begin
         strobe_ff <= accept;
         if (cfg_we) begin
            active_size_ff <= pwdata[SIZE_W-1:0];
            size_m1_ff     <= size_m1_in;
            front_ff       <= '0;
            back_ff        <= '0;
            held_ff        <= '0;
            high_ff        <= '0;
         end else if (accept) begin
            front_ff <= front_in;
            back_ff  <= back_in;
            held_ff  <= held_in;
            high_ff  <= high_in;
            cap_x_ff <= cap_x_in;
            cap_y_ff <= cap_y_in;
         end
      end
   end

   // Result payload registers, loaded on each command transfer.
   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff      <= ok_in;
         sel_mem_ff <= sel_mem_in;
         take_x_ff  <= take_x_in;
         take_y_ff  <= take_y_in;
         empty_ff   <= empty_in;
         afull_ff   <= afull_in;
      end
   end

   // Slot storage.
   rbqs_ram #(
      .WIDTH (SLOTW),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Result outputs; counts are the ring state after the last command.
   assign rsp_strobe      = strobe_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_out_x       = sel_mem_ff ? ram_rdata[WORD_W-1:0] : take_x_ff;
   assign rsp_out_y       = sel_mem_ff ? ram_rdata[SLOTW-1:WORD_W] : take_y_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_almost_full = afull_ff;
   assign rsp_live_count  = COUNT_W'(held_ff);
   assign rsp_peak_count  = COUNT_W'(high_ff);

endmodule
